// ===== src/cesc_pkg.sv =====
// Shared types and codes for the capability entry scanner.
// Holds the result status codes, the result record and the queue entry record.
// No dependencies.
`default_nettype none

package cesc_pkg;

  // Result status codes
  localparam logic [2:0] ST_BYTE = 3'd0;
  localparam logic [2:0] ST_END  = 3'd1;
  localparam logic [2:0] ST_NUM  = 3'd2;
  localparam logic [2:0] ST_FLAG = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;
  localparam logic [2:0] ST_TYPE = 3'd5;

  // Queue between scanner front and result back end
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [15:0] number_value;
  } cesc_result_t;

  // One queue entry: the results caused by one input byte (one or two)
  typedef struct packed {
    logic         two;
    cesc_result_t r0;
    cesc_result_t r1;
  } cesc_entry_t;

  function automatic cesc_result_t mk_res(input logic [2:0] st, input logic [7:0] data,
                                          input logic [15:0] num);
    cesc_result_t r;
    r.status       = st;
    r.data_byte    = data;
    r.number_value = num;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/capability_entry_scanner.sv =====
// Top level of the capability entry scanner: front end, result queue and back end.
// Depends on cesc_pkg, cesc_front, cesc_queue and cesc_back.
// Throughput: one entry byte per cycle unless the queue is full; results leave at one per cycle while popped.
// A result reaches the ports through the result queue and then the back-end output register.
// Push stalls only while the four-entry queue is full; a two-result byte drains over two pops.
// Reset (rst, synchronous): clears registers, scan state and queue.
`default_nettype none

module capability_entry_scanner
  import cesc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  entry_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       status,
  output logic [7:0]       data_byte,
  output logic [15:0]      number_value,
  output logic             run_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic        q_wr, q_rd, q_full, q_empty;
  cesc_entry_t q_wdata, q_rdata;

  assign full      = q_full;
  assign cfg_ready = 1'b1;

  cesc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .entry_byte (entry_byte),
    .q_full     (q_full),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_wr       (q_wr),
    .q_entry    (q_wdata)
  );

  cesc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  cesc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_rdata),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .pop          (pop),
    .empty        (empty),
    .status       (status),
    .data_byte    (data_byte),
    .number_value (number_value),
    .run_last     (run_last)
  );

endmodule

`default_nettype wire

// ===== src/cesc_front.sv =====
// Scanner front end: configuration registers and the per-byte scan state machine.
// Classifies each byte and writes the results it causes into the result queue.
// Depends on cesc_pkg.
`default_nettype none

module cesc_front
  import cesc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [7:0]  entry_byte,
  input  wire logic        q_full,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             q_wr,
  output cesc_entry_t      q_entry
);

  // Scan phases
  localparam logic [3:0] PH_NAME   = 4'd0;
  localparam logic [3:0] PH_FIRST  = 4'd1;
  localparam logic [3:0] PH_SECOND = 4'd2;
  localparam logic [3:0] PH_SKIP   = 4'd3;
  localparam logic [3:0] PH_MARK   = 4'd4;
  localparam logic [3:0] PH_NUM    = 4'd5;
  localparam logic [3:0] PH_STR    = 4'd6;
  localparam logic [3:0] PH_CARET  = 4'd7;
  localparam logic [3:0] PH_ESC    = 4'd8;
  localparam logic [3:0] PH_OCT    = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;

  // Register indexes and query modes
  localparam logic [1:0] REG_ID_FIRST  = 2'd0;
  localparam logic [1:0] REG_ID_SECOND = 2'd1;
  localparam logic [1:0] REG_MODE      = 2'd2;
  localparam logic [1:0] MODE_STRING   = 2'd0;
  localparam logic [1:0] MODE_NUMBER   = 2'd1;
  localparam logic [1:0] MODE_FLAG     = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_E   = 8'h45;

  logic [7:0]  cap_id_first;
  logic [7:0]  cap_id_second;
  logic [1:0]  query_mode;

  logic [3:0]  phase, phase_next;
  logic [7:0]  oct_acc, oct_acc_next;
  logic [15:0] num_acc, num_acc_next;
  logic        fcm, fcm_next;

  logic        accept;
  logic        is_nul, is_digit;
  logic [19:0] num_prod;
  logic [15:0] num_sat;
  logic [7:0]  esc_char;

  // String byte decode, shared by the string phase and the octal exit
  logic         sb_emit, sb_end;
  logic [3:0]   sb_phase;
  cesc_result_t sb_res;

  logic [1:0]   cnt;
  cesc_result_t r0, r1;
  logic         do_end;

  assign accept   = push && !q_full;
  assign is_nul   = (entry_byte == CH_NUL);
  assign is_digit = (entry_byte >= CH_ZERO) && (entry_byte <= CH_NINE);

  // Decimal accumulate: acc * 10 + digit, saturate at 16 bits
  assign num_prod = ({4'b0, num_acc} << 3) + ({4'b0, num_acc} << 1) + {16'b0, entry_byte[3:0]};
  assign num_sat  = (num_prod > 20'd65535) ? 16'hFFFF : num_prod[15:0];

  // Backslash escape translation
  always_comb begin
    case (entry_byte)
      CH_UC_E: esc_char = CH_ESC;
      CH_LC_N: esc_char = 8'd10;
      CH_LC_R: esc_char = 8'd13;
      CH_LC_T: esc_char = 8'd9;
      CH_LC_B: esc_char = 8'd8;
      CH_LC_F: esc_char = 8'd12;
      default: esc_char = entry_byte;
    endcase
  end

  // Plain string byte
  always_comb begin
    sb_emit  = 1'b0;
    sb_end   = 1'b0;
    sb_phase = PH_STR;
    sb_res   = mk_res(ST_BYTE, entry_byte, 16'd0);
    if (is_nul) begin
      sb_emit = 1'b1;
      sb_end  = 1'b1;
      sb_res  = mk_res(ST_END, 8'd0, 16'd0);
    end else if (entry_byte == CH_COLON) begin
      sb_emit  = 1'b1;
      sb_phase = PH_DONE;
      sb_res   = mk_res(ST_END, 8'd0, 16'd0);
    end else if (entry_byte == CH_CARET) begin
      sb_phase = PH_CARET;
    end else if (entry_byte == CH_BSLASH) begin
      sb_phase = PH_ESC;
    end else begin
      sb_emit = 1'b1;
    end
  end

  // Scan state machine
  always_comb begin
    phase_next   = phase;
    oct_acc_next = oct_acc;
    num_acc_next = num_acc;
    fcm_next     = fcm;
    cnt          = 2'd0;
    r0           = mk_res(ST_NONE, 8'd0, 16'd0);
    r1           = sb_res;
    do_end       = 1'b0;
    case (phase)
      PH_NAME: begin
        if (is_nul) begin
          cnt = 2'd1; do_end = 1'b1;
        end else if (entry_byte == CH_COLON) begin
          phase_next = PH_FIRST;
        end
      end
      PH_FIRST: begin
        if (is_nul) begin
          cnt = 2'd1; do_end = 1'b1;
        end else if (entry_byte != CH_COLON) begin
          fcm_next   = (entry_byte == cap_id_first);
          phase_next = PH_SECOND;
        end
      end
      PH_SECOND: begin
        fcm_next = 1'b0;
        if (is_nul) begin
          cnt = 2'd1; do_end = 1'b1;
        end else if (entry_byte == CH_COLON) begin
          phase_next = PH_FIRST;
        end else if (fcm && entry_byte == cap_id_second) begin
          if (query_mode == MODE_FLAG) begin
            cnt        = 2'd1;
            r0         = mk_res(ST_FLAG, 8'd0, 16'd0);
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_MARK;
          end
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (is_nul) begin
          cnt = 2'd1; do_end = 1'b1;
        end else if (entry_byte == CH_COLON) begin
          phase_next = PH_FIRST;
        end
      end
      PH_MARK: begin
        if (query_mode == MODE_STRING && entry_byte == CH_EQ) begin
          phase_next = PH_STR;
        end else if (query_mode == MODE_NUMBER && entry_byte == CH_HASH) begin
          num_acc_next = 16'd0;
          phase_next   = PH_NUM;
        end else begin
          cnt        = 2'd1;
          r0         = mk_res(ST_TYPE, 8'd0, 16'd0);
          do_end     = is_nul;
          phase_next = PH_DONE;
        end
      end
      PH_NUM: begin
        if (is_digit) begin
          num_acc_next = num_sat;
        end else begin
          cnt        = 2'd1;
          r0         = mk_res(ST_NUM, 8'd0, num_acc);
          do_end     = is_nul;
          phase_next = PH_DONE;
        end
      end
      PH_STR: begin
        cnt        = {1'b0, sb_emit};
        r0         = sb_res;
        do_end     = sb_end;
        phase_next = sb_phase;
      end
      PH_CARET: begin
        cnt = 2'd1;
        if (is_nul) begin
          r0     = mk_res(ST_END, 8'd0, 16'd0);
          do_end = 1'b1;
        end else begin
          r0         = mk_res(ST_BYTE, entry_byte - CH_A, 16'd0);
          phase_next = PH_STR;
        end
      end
      PH_ESC: begin
        phase_next = PH_STR;
        if (is_nul) begin
          cnt    = 2'd1;
          r0     = mk_res(ST_END, 8'd0, 16'd0);
          do_end = 1'b1;
        end else if (entry_byte >= CH_ZERO && entry_byte <= CH_THREE) begin
          oct_acc_next = {6'd0, entry_byte[1:0]};
          phase_next   = PH_OCT;
        end else begin
          cnt = 2'd1;
          r0  = mk_res(ST_BYTE, esc_char, 16'd0);
        end
      end
      PH_OCT: begin
        if (is_digit) begin
          oct_acc_next = {oct_acc[4:0], 3'b000} + {4'd0, entry_byte[3:0]};
        end else begin
          cnt          = sb_emit ? 2'd2 : 2'd1;
          r0           = mk_res(ST_BYTE, oct_acc, 16'd0);
          oct_acc_next = 8'd0;
          do_end       = sb_end;
          phase_next   = sb_phase;
        end
      end
      default: begin
        do_end     = is_nul;
        phase_next = PH_DONE;
      end
    endcase
    // Zero byte closes the entry and rewinds the scan
    if (do_end) begin
      phase_next   = PH_NAME;
      oct_acc_next = 8'd0;
      num_acc_next = 16'd0;
      fcm_next     = 1'b0;
    end
  end

  // Hand results to the queue
  assign q_wr    = accept && (cnt != 2'd0);
  assign q_entry = '{two: cnt[1], r0: r0, r1: r1};

  // Advance scan state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_NAME;
      oct_acc <= 8'd0;
      num_acc <= 16'd0;
      fcm     <= 1'b0;
    end else if (accept) begin
      phase   <= phase_next;
      oct_acc <= oct_acc_next;
      num_acc <= num_acc_next;
      fcm     <= fcm_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_id_first  <= 8'd0;
      cap_id_second <= 8'd0;
      query_mode    <= MODE_STRING;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ID_FIRST:  cap_id_first  <= cfg_data;
        REG_ID_SECOND: cap_id_second <= cfg_data;
        REG_MODE:      query_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cesc_queue.sv =====
// Small register queue between the scanner front end and the result back end.
// Each entry carries the one or two results caused by one input byte.
// Depends on cesc_pkg.
`default_nettype none

module cesc_queue
  import cesc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  wire cesc_entry_t wr_data,
  input  wire logic  rd,
  output cesc_entry_t rd_data,
  output logic       full,
  output logic       empty
);

  cesc_entry_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr, do_rd;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (!do_wr && do_rd) count <= count - 1'b1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue occupancy above depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue occupancy did not grow on write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != QCNT_W'(QDEPTH)) |-> (wr_ptr - rd_ptr == count[QPTR_W-1:0]))
    else $error("queue pointers disagree with occupancy");

  a_reset: assert property (@(posedge clk)
    rst |=> (count == '0))
    else $error("queue not empty after reset");

endmodule

`default_nettype wire

// ===== src/cesc_back.sv =====
// Result back end: output register that unpacks queue entries into single results.
// Presents the oldest result and marks the last result of each input byte.
// Depends on cesc_pkg.
`default_nettype none

module cesc_back
  import cesc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cesc_entry_t q_data,
  input  wire logic   q_empty,
  output logic        q_rd,
  input  wire logic   pop,
  output logic        empty,
  output logic [2:0]  status,
  output logic [7:0]  data_byte,
  output logic [15:0] number_value,
  output logic        run_last
);

  cesc_entry_t  cur;
  logic         cur_valid;
  logic         sel;
  logic         last, transfer, load;
  cesc_result_t shown;

  assign last     = !cur.two || sel;
  assign transfer = pop && cur_valid;
  assign load     = !cur_valid || (transfer && last);
  assign q_rd     = load && !q_empty;

  assign shown        = sel ? cur.r1 : cur.r0;
  assign empty        = !cur_valid;
  assign status       = shown.status;
  assign data_byte    = shown.data_byte;
  assign number_value = shown.number_value;
  assign run_last     = last;

  // Hold the current entry; step to its second result or reload from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      cur_valid <= !q_empty;
      sel       <= 1'b0;
    end else if (transfer) begin
      sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

endmodule

`default_nettype wire
